FILE: hw/rtl/upx_pkg.sv
// ----------------------------------------------------------------------------
// upx_pkg
// Shared types and constants for the 2x pixel-art upscaler.
// ----------------------------------------------------------------------------
package upx_pkg;

    localparam logic [15:0] MASK_565 = 16'hF7DE;
    localparam logic [15:0] MASK_555 = 16'h7BDE;

    typedef logic [15:0] t_pix;

    typedef struct packed {
        t_pix pix_up_left;
        t_pix pix_up;
        t_pix pix_up_right;
        t_pix pix_left;
        t_pix pix_center;
        t_pix pix_right;
        t_pix pix_down_left;
        t_pix pix_down;
        t_pix pix_down_right;
    } t_pix_in;

    typedef struct packed {
        t_pix out_top_left;
        t_pix out_top_right;
        t_pix out_bottom_left;
        t_pix out_bottom_right;
    } t_pix_out;

    // pixels still needed after the compare stage
    typedef struct packed {
        t_pix e;
        t_pix b;
        t_pix d;
        t_pix h;
    } t_pix_keep;

    // neighbour equality flags, a..i in raster order of the 3x3 window
    typedef struct packed {
        logic ab, ad, ae, af, ah;
        logic bc, bd, be, bf, bg, bh, bi;
        logic cd, ce, cf, ch;
        logic de, df, dg, dh, di;
        logic ef, eg, ei;
        logic fg, fh, fi;
        logic gh, hi;
    } t_eq;

    typedef enum logic [2:0] {
        SEL_E    = 3'd0,
        SEL_H    = 3'd1,
        SEL_BL_B = 3'd2,
        SEL_BL_H = 3'd3,
        SEL_BL_D = 3'd4
    } t_sel;

    typedef struct packed {
        t_sel q0;
        t_sel q1;
        t_sel q2;
        t_sel q3;
    } t_sel_set;

endpackage

FILE: hw/rtl/upx_cmp.sv
// ----------------------------------------------------------------------------
// upx_cmp
// Stage 1: equality tests across the 3x3 neighbourhood.
// ----------------------------------------------------------------------------
module upx_cmp import upx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_pix_in   i_pix,
    output logic      o_valid,
    output t_eq       o_eq,
    output t_pix_keep o_pix
);

    t_pix a, b, c, d, e, f, g, h, i;
    t_eq  n_eq;
    t_pix_keep n_pix;
    logic r_valid;
    t_eq  r_eq;
    t_pix_keep r_pix;

    always_comb begin
        a = i_pix.pix_up_left;
        b = i_pix.pix_up;
        c = i_pix.pix_up_right;
        d = i_pix.pix_left;
        e = i_pix.pix_center;
        f = i_pix.pix_right;
        g = i_pix.pix_down_left;
        h = i_pix.pix_down;
        i = i_pix.pix_down_right;

        n_eq.ab = (a == b);
        n_eq.ad = (a == d);
        n_eq.ae = (a == e);
        n_eq.af = (a == f);
        n_eq.ah = (a == h);
        n_eq.bc = (b == c);
        n_eq.bd = (b == d);
        n_eq.be = (b == e);
        n_eq.bf = (b == f);
        n_eq.bg = (b == g);
        n_eq.bh = (b == h);
        n_eq.bi = (b == i);
        n_eq.cd = (c == d);
        n_eq.ce = (c == e);
        n_eq.cf = (c == f);
        n_eq.ch = (c == h);
        n_eq.de = (d == e);
        n_eq.df = (d == f);
        n_eq.dg = (d == g);
        n_eq.dh = (d == h);
        n_eq.di = (d == i);
        n_eq.ef = (e == f);
        n_eq.eg = (e == g);
        n_eq.ei = (e == i);
        n_eq.fg = (f == g);
        n_eq.fh = (f == h);
        n_eq.fi = (f == i);
        n_eq.gh = (g == h);
        n_eq.hi = (h == i);

        n_pix.e = e;
        n_pix.b = b;
        n_pix.d = d;
        n_pix.h = h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_eq  <= n_eq;
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_eq    = r_eq;
    assign o_pix   = r_pix;

endmodule

FILE: hw/rtl/upx_decide.sv
// ----------------------------------------------------------------------------
// upx_decide
// Stage 2: edge classification, picks a source for each output pixel.
// ----------------------------------------------------------------------------
module upx_decide import upx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_eq       i_eq,
    input  t_pix_keep i_pix,
    output logic      o_valid,
    output t_sel_set  o_sel,
    output t_pix_keep o_pix
);

    logic hz1, hz2, diag, four;
    logic u0, u1, l2, l3;
    t_sel_set n_sel;
    logic r_valid;
    t_sel_set r_sel;
    t_pix_keep r_pix;

    always_comb begin
        hz1 = !i_eq.df && !i_eq.de && i_eq.dh && i_eq.di && !i_eq.eg
            && (!i_eq.dg || !i_eq.ef || !i_eq.ad)
            && !(i_eq.ad && i_eq.dg && i_eq.be && i_eq.ef);
        hz2 = !i_eq.df && !i_eq.ef && i_eq.fh && i_eq.fg && !i_eq.ei
            && (!i_eq.fi || !i_eq.de || !i_eq.cf)
            && !(i_eq.cf && i_eq.fi && i_eq.be && i_eq.de);

        diag = !i_eq.bh && !i_eq.df;
        four = i_eq.bd && i_eq.df && i_eq.dh && !i_eq.de;

        u0 = i_eq.bd && !i_eq.de
            && !(i_eq.ef && ((i_eq.ae && i_eq.bc)
                 || (i_eq.ad && i_eq.cd && !i_eq.dg && !i_eq.eg)))
            && !(i_eq.ab && i_eq.bg);
        u1 = i_eq.bf && !i_eq.ef
            && !(i_eq.de && ((i_eq.ce && i_eq.ab)
                 || (i_eq.af && i_eq.cf && !i_eq.fi && !i_eq.ei)))
            && !(i_eq.bc && i_eq.bi);
        l2 = i_eq.dh && (!i_eq.eg || !i_eq.de || (!i_eq.ef && i_eq.fi))
            && !(i_eq.ef && ((i_eq.eg && i_eq.hi)
                 || (i_eq.dg && i_eq.di && !i_eq.ad && !i_eq.ae)))
            && !(i_eq.gh && i_eq.ah);
        l3 = i_eq.fh && (!i_eq.ei || !i_eq.ef)
            && !(i_eq.de && ((i_eq.ei && i_eq.gh)
                 || (i_eq.fg && i_eq.fi && !i_eq.cf && !i_eq.ei)))
            && !(i_eq.hi && i_eq.ch);

        n_sel.q0 = SEL_E;
        n_sel.q1 = SEL_E;
        n_sel.q2 = SEL_E;
        n_sel.q3 = SEL_E;

        priority if (hz1) begin
            n_sel.q2 = SEL_H;
            n_sel.q3 = SEL_BL_H;
        end else if (hz2) begin
            n_sel.q2 = SEL_BL_H;
            n_sel.q3 = SEL_H;
        end else if (diag) begin
            if (u0) begin
                n_sel.q0 = SEL_BL_B;
            end else if (u1) begin
                n_sel.q1 = SEL_BL_B;
            end
            if (l2) begin
                n_sel.q2 = SEL_BL_H;
            end else if (l3) begin
                n_sel.q3 = SEL_BL_H;
            end
        end else if (four) begin
            if (i_eq.dg || i_eq.cd) begin
                n_sel.q1 = SEL_BL_D;
                n_sel.q2 = SEL_BL_D;
            end
            if (i_eq.ad || i_eq.di) begin
                n_sel.q0 = SEL_BL_D;
                n_sel.q3 = SEL_BL_D;
            end
        end else begin
            n_sel.q0 = SEL_E;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_sel <= n_sel;
            r_pix <= i_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_sel   = r_sel;
    assign o_pix   = r_pix;

endmodule

FILE: hw/rtl/upx_blend.sv
// ----------------------------------------------------------------------------
// upx_blend
// Stage 3: half-blends and output pixel selection into the result register.
// ----------------------------------------------------------------------------
module upx_blend import upx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_sel_set  i_sel,
    input  t_pix_keep i_pix,
    input  logic      i_format_565,
    output logic      o_valid,
    output t_pix_out  o_out
);

    t_pix mask;
    t_pix bl_b, bl_h, bl_d;
    t_pix_out n_out;
    logic r_valid;
    t_pix_out r_out;

    function automatic t_pix pick(input t_sel sel, input t_pix e, input t_pix h,
                                  input t_pix bb, input t_pix bh, input t_pix bd);
        t_pix res;
        unique case (sel)
            SEL_E:    res = e;
            SEL_H:    res = h;
            SEL_BL_B: res = bb;
            SEL_BL_H: res = bh;
            SEL_BL_D: res = bd;
            default:  res = e;
        endcase
        return res;
    endfunction

    always_comb begin
        mask = i_format_565 ? MASK_565 : MASK_555;
        bl_b = ((i_pix.e & mask) >> 1) + ((i_pix.b & mask) >> 1);
        bl_h = ((i_pix.e & mask) >> 1) + ((i_pix.h & mask) >> 1);
        bl_d = ((i_pix.e & mask) >> 1) + ((i_pix.d & mask) >> 1);

        n_out.out_top_left     = pick(i_sel.q0, i_pix.e, i_pix.h, bl_b, bl_h, bl_d);
        n_out.out_top_right    = pick(i_sel.q1, i_pix.e, i_pix.h, bl_b, bl_h, bl_d);
        n_out.out_bottom_left  = pick(i_sel.q2, i_pix.e, i_pix.h, bl_b, bl_h, bl_d);
        n_out.out_bottom_right = pick(i_sel.q3, i_pix.e, i_pix.h, bl_b, bl_h, bl_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

FILE: hw/rtl/pixel_art_2x_upscaler.sv
// ----------------------------------------------------------------------------
// pixel_art_2x_upscaler
// 2x edge-aware upscaler for 16-bit RGB565/RGB555 pixel windows.
// ----------------------------------------------------------------------------
// Accepts one 3x3 source window per clock; busy is never raised. Each
// transaction produces one 2x2 output block on o_result, registered by each
// stage, qualified by o_result_valid for a single cycle. The three stages are
// neighbour compares, edge classification, and blend/select. The receiver
// cannot stall, so results must be captured when the strobe is high. The
// format register is written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module pixel_art_2x_upscaler import upx_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_pix_in  i_pix,
    output logic     o_result_valid,
    output t_pix_out o_result,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic     i_cfg_data
);

    logic      r_format_565;
    logic      in_accept;
    logic      s1_valid, s2_valid;
    t_eq       s1_eq;
    t_pix_keep s1_pix, s2_pix;
    t_sel_set  s2_sel;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_565 <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_format_565 <= i_cfg_data;
        end
    end

    upx_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_accept),
        .i_pix   (i_pix),
        .o_valid (s1_valid),
        .o_eq    (s1_eq),
        .o_pix   (s1_pix)
    );

    upx_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_eq    (s1_eq),
        .i_pix   (s1_pix),
        .o_valid (s2_valid),
        .o_sel   (s2_sel),
        .o_pix   (s2_pix)
    );

    upx_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s2_valid),
        .i_sel        (s2_sel),
        .i_pix        (s2_pix),
        .i_format_565 (r_format_565),
        .o_valid      (o_result_valid),
        .o_out        (o_result)
    );

endmodule
